/* rtl/lpfc_pkg.sv */
`timescale 1ns / 1ps

package lpfc_pkg;

  // frame limits and crc constants
  localparam logic [7:0] MIN_FRAME_LEN   = 8'd5;
  localparam logic [7:0] MAX_LEN_RESET   = 8'd64;
  localparam logic [7:0] CRC_POLY        = 8'h8C;
  localparam logic [7:0] CRC_INIT        = 8'h00;

  // per-byte frame status
  typedef enum logic [1:0] {
    ST_GOOD   = 2'd0,
    ST_SHORT  = 2'd1,
    ST_LONG   = 2'd2,
    ST_BADCRC = 2'd3
  } status_t;

  // one tagged output byte
  typedef struct packed {
    logic [7:0] data_byte;
    logic [7:0] byte_index;
    logic       last_byte;
    status_t    frame_status;
  } result_t;

  // reflected crc-8, lsb first, one byte
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    logic [7:0] d;
    logic       mix;
    c = crc;
    d = b;
    for (int k = 0; k < 8; k++) begin
      mix = c[0] ^ d[0];
      c   = {1'b0, c[7:1]};
      if (mix) begin
        c = c ^ CRC_POLY;
      end
      d = {1'b0, d[7:1]};
    end
    return c;
  endfunction

endpackage

/* rtl/lpfc_in_stage.sv */
`timescale 1ns / 1ps

module lpfc_in_stage
  import lpfc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       a_valid,
  output logic [7:0] a_byte,
  input  logic       a_take
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] byte_r;
  logic       in_fire;

  // hold off only while a byte waits and downstream cannot take it
  assign in_stall = valid_r && !a_take;
  assign in_fire  = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (a_take) begin
      valid_nxt = 1'b0;
    end
    if (in_fire) begin
      valid_nxt = 1'b1;
    end
  end

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (in_fire) begin
      byte_r <= in_rx_byte;
    end
  end

  assign a_valid = valid_r;
  assign a_byte  = byte_r;

endmodule

/* rtl/lpfc_frame_ctrl.sv */
`timescale 1ns / 1ps

module lpfc_frame_ctrl
  import lpfc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] max_len,
  input  logic       a_valid,
  input  logic [7:0] a_byte,
  output logic       a_take,
  output logic       res_valid,
  output result_t    res,
  input  logic       out_stall
);

  logic       res_valid_r;
  logic       res_valid_nxt;
  result_t    res_r;
  result_t    res_nxt;
  logic [7:0] crc_r;
  logic [7:0] crc_nxt;
  logic [7:0] seen_r;
  logic [7:0] seen_nxt;
  logic [7:0] flen_r;
  logic [7:0] flen_nxt;
  logic       out_free;
  logic [8:0] seen_plus;

  // result register frees when empty or its transfer completes
  assign out_free = !res_valid_r || !out_stall;
  assign a_take   = a_valid && out_free;
  assign seen_plus = {1'b0, seen_r} + 9'd1;

  // frame decode for the byte in the input register
  always_comb begin
    crc_nxt  = crc_r;
    seen_nxt = seen_r;
    flen_nxt = flen_r;
    res_nxt.data_byte    = a_byte;
    res_nxt.byte_index   = seen_r;
    res_nxt.last_byte    = 1'b0;
    res_nxt.frame_status = ST_GOOD;
    if (seen_r == 8'd0) begin
      if (a_byte < MIN_FRAME_LEN) begin
        res_nxt.last_byte    = 1'b1;
        res_nxt.frame_status = ST_SHORT;
        crc_nxt              = CRC_INIT;
      end else if (a_byte > max_len) begin
        res_nxt.last_byte    = 1'b1;
        res_nxt.frame_status = ST_LONG;
        crc_nxt              = CRC_INIT;
      end else begin
        flen_nxt = a_byte;
        crc_nxt  = crc8_update(CRC_INIT, a_byte);
        seen_nxt = 8'd1;
      end
    end else if (seen_plus >= {1'b0, flen_r}) begin
      res_nxt.last_byte    = 1'b1;
      res_nxt.frame_status = (a_byte == crc_r) ? ST_GOOD : ST_BADCRC;
      seen_nxt             = 8'd0;
      crc_nxt              = CRC_INIT;
    end else begin
      crc_nxt  = crc8_update(crc_r, a_byte);
      seen_nxt = seen_plus[7:0];
    end
  end

  always_comb begin
    res_valid_nxt = res_valid_r;
    if (!out_stall) begin
      res_valid_nxt = 1'b0;
    end
    if (a_take) begin
      res_valid_nxt = 1'b1;
    end
  end

  // frame state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
      crc_r       <= CRC_INIT;
      seen_r      <= 8'd0;
      flen_r      <= 8'd0;
    end else begin
      res_valid_r <= res_valid_nxt;
      if (a_take) begin
        crc_r  <= crc_nxt;
        seen_r <= seen_nxt;
        flen_r <= flen_nxt;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (a_take) begin
      res_r <= res_nxt;
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

`ifndef SYNTHESIS
  a_err_at_len_byte: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r && (res_r.frame_status == ST_SHORT || res_r.frame_status == ST_LONG)
    |-> res_r.last_byte && res_r.byte_index == 8'd0)
    else $error("length error not on a length byte");

  a_last_resyncs: assert property (@(posedge clk) disable iff (!rst_n)
    a_take && res_nxt.last_byte |=> seen_r == 8'd0)
    else $error("frame end did not return to length byte");

  a_len_legal: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r != 8'd0 |-> flen_r >= MIN_FRAME_LEN)
    else $error("running frame with illegal length");

  a_seen_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r != 8'd0 |-> seen_r < flen_r)
    else $error("byte count ran past frame length");
`endif

endmodule

/* rtl/length_prefixed_frame_crc8_checker.sv */
`timescale 1ns / 1ps

// channel  dir  handshake          payload
// in_      in   in_valid/in_stall  in_rx_byte[7:0]
// out_     out  out_valid/out_stall out_data_byte, out_byte_index, out_last_byte,
//                                  out_frame_status
// cfg_     in   cfg_valid/cfg_ready cfg_max_frame_length[7:0]
//
// one byte per cycle sustained while out_stall is low; a byte passes from its transfer to the output
// through the input register, then frame decode and crc-8 into the result register
// synchronous active-low reset: limit back to 64, frame state to awaiting length byte
// out_stall backs up into in_stall only when both registers hold a byte
// cfg_ready is always high; a write takes effect on the next length byte

module length_prefixed_frame_crc8_checker
  import lpfc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_data_byte,
  output logic [7:0] out_byte_index,
  output logic       out_last_byte,
  output logic [1:0] out_frame_status,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_max_frame_length
);

  logic       a_valid;
  logic [7:0] a_byte;
  logic       a_take;
  result_t    res;
  logic [7:0] max_len_r;

  // configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_len_r <= cfg_max_frame_length;
    end
  end

  lpfc_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .a_valid    (a_valid),
    .a_byte     (a_byte),
    .a_take     (a_take)
  );

  lpfc_frame_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .max_len   (max_len_r),
    .a_valid   (a_valid),
    .a_byte    (a_byte),
    .a_take    (a_take),
    .res_valid (out_valid),
    .res       (res),
    .out_stall (out_stall)
  );

  // result fields out
  assign out_data_byte    = res.data_byte;
  assign out_byte_index   = res.byte_index;
  assign out_last_byte    = res.last_byte;
  assign out_frame_status = res.frame_status;

endmodule
